>>> sv/pmx_pkg.sv
package pmx_pkg;

  localparam int GENE_W = 6;
  localparam int TLEN_W = 7;
  localparam logic [TLEN_W-1:0] TLEN_RESET = 7'd64;
  localparam logic [TLEN_W-1:0] TLEN_MIN = 7'd2;

  typedef struct packed {
    logic load_we;
    logic start;
    logic idx_to_zero;
    logic idx_inc;
    logic map_we;
    logic chain_init;
    logic chain_step;
    logic out_load;
  } pmx_cmd_t;

  typedef struct packed {
    logic build_done;
    logic chain_busy;
    logic last_pos;
  } pmx_sts_t;

endpackage

>>> sv/pmx_ctrl.sv
module pmx_ctrl import pmx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_mode,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output pmx_cmd_t  cmd,
  input  pmx_sts_t  sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_B_RD   = 3'd1;
  localparam logic [2:0] S_B_WR   = 3'd2;
  localparam logic [2:0] S_E_RD   = 3'd3;
  localparam logic [2:0] S_E_CHK  = 3'd4;
  localparam logic [2:0] S_C_TEST = 3'd5;
  localparam logic [2:0] S_C_UPD  = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_mode) begin
            cmd.start = 1'b1;
            state_nxt = S_B_RD;
          end else begin
            cmd.load_we = 1'b1;
          end
        end
      end
      S_B_RD: state_nxt = S_B_WR;
      S_B_WR: begin
        cmd.map_we = 1'b1;
        if (sts.build_done) begin
          cmd.idx_to_zero = 1'b1;
          state_nxt       = S_E_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_B_RD;
        end
      end
      S_E_RD: state_nxt = S_E_CHK;
      S_E_CHK: begin
        cmd.chain_init = 1'b1;
        state_nxt      = S_C_TEST;
      end
      S_C_TEST: begin
        if (sts.chain_busy) begin
          state_nxt = S_C_UPD;
        end else begin
          cmd.out_load = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_C_UPD: begin
        cmd.chain_step = 1'b1;
        state_nxt      = S_C_TEST;
      end
      S_OUT: begin
        if (out_tready) begin
          if (sts.last_pos) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_E_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/pmx_dpath.sv
module pmx_dpath import pmx_pkg::*; #(
  parameter int MAX_GENES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [TLEN_W-1:0] cfg_wdata,
  input  logic [GENE_W-1:0] in_position,
  input  logic [GENE_W-1:0] in_first_gene,
  input  logic [GENE_W-1:0] in_second_gene,
  input  logic [GENE_W-1:0] in_cut_low,
  input  logic [GENE_W-1:0] in_cut_high,
  input  pmx_cmd_t          cmd,
  output pmx_sts_t          sts,
  output logic [23:0]       out_tdata,
  output logic              out_tlast
);

  localparam int DEPTH = (MAX_GENES < 64) ? MAX_GENES : 64;
  localparam int AW    = $clog2(DEPTH);

  logic [TLEN_W-1:0] tlen_r;
  logic [TLEN_W-1:0] n_len;
  logic [GENE_W-1:0] last_idx;

  logic [GENE_W-1:0] lo_sw, hi_sw, lo_cl, hi_cl;
  logic [GENE_W-1:0] lo_r, hi_r, idx_r;

  logic [GENE_W-1:0] fp_mem [DEPTH];
  logic [GENE_W-1:0] sp_mem [DEPTH];
  logic [GENE_W-1:0] m1_mem [DEPTH];
  logic [GENE_W-1:0] m2_mem [DEPTH];
  logic [GENE_W-1:0] fp_rd_r, sp_rd_r, m1_rd_r, m2_rd_r;
  logic [DEPTH-1:0]  mv1_r, mv2_r;

  logic [GENE_W-1:0] v1_r, v2_r;
  logic [TLEN_W-1:0] steps_r;
  logic              seg_r;
  logic              in_seg, act1, act2;
  logic              pos_ok, fp_ok, sp_ok, v1_ok, v2_ok;

  logic [GENE_W-1:0] o_pos_r, o_c1_r, o_c2_r;
  logic              o_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlen_r <= TLEN_RESET;
    end else if (cfg_we) begin
      tlen_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (tlen_r < TLEN_MIN) begin
      n_len = TLEN_MIN;
    end else if (tlen_r > TLEN_W'(DEPTH)) begin
      n_len = TLEN_W'(DEPTH);
    end else begin
      n_len = tlen_r;
    end
  end
  assign last_idx = GENE_W'(n_len - 7'd1);

  // cut ordering and clamp
  assign lo_sw = (in_cut_low > in_cut_high) ? in_cut_high : in_cut_low;
  assign hi_sw = (in_cut_low > in_cut_high) ? in_cut_low : in_cut_high;
  assign lo_cl = (lo_sw > last_idx) ? last_idx : lo_sw;
  assign hi_cl = (hi_sw > last_idx) ? last_idx : hi_sw;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lo_r  <= lo_cl;
      hi_r  <= hi_cl;
      idx_r <= lo_cl;
    end else if (cmd.idx_to_zero) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 6'd1;
    end
  end

  // parent stores
  assign pos_ok = (32'(in_position) < MAX_GENES);

  always_ff @(posedge clk) begin
    if (cmd.load_we && pos_ok) begin
      fp_mem[in_position[AW-1:0]] <= in_first_gene;
      sp_mem[in_position[AW-1:0]] <= in_second_gene;
    end
    fp_rd_r <= fp_mem[idx_r[AW-1:0]];
    sp_rd_r <= sp_mem[idx_r[AW-1:0]];
  end

  // segment maps: data in memory, valid bits in flops
  assign fp_ok = (32'(fp_rd_r) < MAX_GENES);
  assign sp_ok = (32'(sp_rd_r) < MAX_GENES);

  always_ff @(posedge clk) begin
    if (cmd.map_we && sp_ok) begin
      m1_mem[sp_rd_r[AW-1:0]] <= fp_rd_r;
    end
    if (cmd.map_we && fp_ok) begin
      m2_mem[fp_rd_r[AW-1:0]] <= sp_rd_r;
    end
    m1_rd_r <= m1_mem[v1_r[AW-1:0]];
    m2_rd_r <= m2_mem[v2_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.start) begin
      mv1_r <= '0;
      mv2_r <= '0;
    end else if (cmd.map_we) begin
      if (sp_ok) begin
        mv1_r[sp_rd_r[AW-1:0]] <= 1'b1;
      end
      if (fp_ok) begin
        mv2_r[fp_rd_r[AW-1:0]] <= 1'b1;
      end
    end
  end

  // mapping chains, stepped together
  assign in_seg = (idx_r >= lo_r) && (idx_r <= hi_r);
  assign v1_ok  = (32'(v1_r) < MAX_GENES);
  assign v2_ok  = (32'(v2_r) < MAX_GENES);
  assign act1   = !seg_r && (steps_r < n_len) && v1_ok && mv1_r[v1_r[AW-1:0]];
  assign act2   = !seg_r && (steps_r < n_len) && v2_ok && mv2_r[v2_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.chain_init) begin
      v1_r    <= in_seg ? sp_rd_r : fp_rd_r;
      v2_r    <= in_seg ? fp_rd_r : sp_rd_r;
      seg_r   <= in_seg;
      steps_r <= '0;
    end else if (cmd.chain_step) begin
      if (act1) begin
        v1_r <= m1_rd_r;
      end
      if (act2) begin
        v2_r <= m2_rd_r;
      end
      steps_r <= steps_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_pos_r  <= idx_r;
      o_c1_r   <= v1_r;
      o_c2_r   <= v2_r;
      o_last_r <= (idx_r == last_idx);
    end
  end

  assign sts.build_done = (idx_r == hi_r);
  assign sts.chain_busy = act1 || act2;
  assign sts.last_pos   = (idx_r == last_idx);

  assign out_tdata = {6'd0, o_c2_r, o_c1_r, o_pos_r};
  assign out_tlast = o_last_r;

endmodule

>>> sv/pmx_permutation_crossover.sv
// Partially mapped crossover of two parent permutations.
// Input channel (in_): tuser is the mode. Mode 0 loads one gene pair at a
// position and gives no output beat. Mode 1 carries the two cut points and
// starts a crossover run over positions 0 .. L-1, where L is tour_length
// clamped to 2 .. min(MAX_GENES, 64).
// Output channel (out_): one beat per position with both child genes;
// tlast marks position L-1.
// A run first builds the segment maps, a parent read and a map write per
// segment position, then for each position reads the parents and steps both
// mapping chains together (one map memory read each) before the beat is shown.
// in_tready is low for the whole run. The output register holds a beat
// until out_tready takes it; the next position starts only then, so a
// stalled receiver simply stretches the run.
// Reset sets tour_length to 64 and returns the controller to idle; the
// parent stores hold nothing defined until loaded.
// cfg_we writes tour_length; write it only while no run is in progress.
module pmx_permutation_crossover import pmx_pkg::*; #(
  parameter int MAX_GENES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,   // tour_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // position, first_parent_gene,
                                   // second_parent_gene, cut_low, cut_high
  input  logic        in_tuser,    // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // out_position, child_one_gene, child_two_gene
  output logic        out_tlast
);

  pmx_cmd_t cmd;
  pmx_sts_t sts;

  pmx_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_mode    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  pmx_dpath #(
    .MAX_GENES (MAX_GENES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_position    (in_tdata[5:0]),
    .in_first_gene  (in_tdata[11:6]),
    .in_second_gene (in_tdata[17:12]),
    .in_cut_low     (in_tdata[23:18]),
    .in_cut_high    (in_tdata[29:24]),
    .cmd            (cmd),
    .sts            (sts),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast)
  );

endmodule

>>> bench/pmx_tb_pkg.sv
`timescale 1ns / 1ps
package pmx_tb_pkg;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_CROSS = 1'b1
  } pmx_mode_e;

endpackage

>>> bench/pmx_checker.sv
`timescale 1ns / 1ps
module pmx_checker import pmx_pkg::*, pmx_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  output int          mismatches,
  output int          beats_due
);

  typedef struct packed {
    logic [GENE_W-1:0] position;
    logic [GENE_W-1:0] child_one;
    logic [GENE_W-1:0] child_two;
    logic              last;
  } child_beat_t;

  logic [TLEN_W-1:0] tour_len;
  logic [GENE_W-1:0] parent_one [64];
  logic [GENE_W-1:0] parent_two [64];
  logic [GENE_W:0]   seg_map_one [64];
  logic [GENE_W:0]   seg_map_two [64];
  child_beat_t       children_due [$];

  // follow the segment map until the gene leaves it, at most limit steps
  function automatic logic [GENE_W-1:0] trace_gene(input logic use_two,
                                                   input logic [GENE_W-1:0] gene,
                                                   input int unsigned limit);
    logic [GENE_W-1:0] g;
    logic [GENE_W:0]   ent;
    int unsigned       steps;
    g = gene;
    steps = 0;
    ent = use_two ? seg_map_two[g] : seg_map_one[g];
    while (steps < limit && ent[GENE_W]) begin
      g = ent[GENE_W-1:0];
      steps++;
      ent = use_two ? seg_map_two[g] : seg_map_one[g];
    end
    return g;
  endfunction

  function automatic void predict_children(input logic [GENE_W-1:0] cut_a,
                                           input logic [GENE_W-1:0] cut_b);
    int unsigned n, lo, hi, i;
    child_beat_t b;
    n = 32'(tour_len);
    if (n < 2) n = 2;
    if (n > 64) n = 64;
    lo = 32'(cut_a);
    hi = 32'(cut_b);
    if (lo > hi) begin
      lo = 32'(cut_b);
      hi = 32'(cut_a);
    end
    if (lo > n - 1) lo = n - 1;
    if (hi > n - 1) hi = n - 1;
    for (i = 0; i < 64; i++) begin
      seg_map_one[i] = '0;
      seg_map_two[i] = '0;
    end
    for (i = lo; i <= hi; i++) begin
      seg_map_one[parent_two[i]] = {1'b1, parent_one[i]};
      seg_map_two[parent_one[i]] = {1'b1, parent_two[i]};
    end
    for (i = 0; i < n; i++) begin
      b.position = i[GENE_W-1:0];
      if (i >= lo && i <= hi) begin
        b.child_one = parent_two[i];
        b.child_two = parent_one[i];
      end else begin
        b.child_one = trace_gene(1'b0, parent_one[i], n);
        b.child_two = trace_gene(1'b1, parent_two[i], n);
      end
      b.last = (i == n - 1);
      children_due.push_back(b);
    end
  endfunction

  always @(posedge clk) begin : watch
    child_beat_t got, want;
    if (!rst_n) begin
      tour_len = TLEN_RESET;
      children_due.delete();
    end else begin
      if (cfg_we) tour_len = cfg_wdata;
      if (out_tvalid && out_tready) begin
        got.position  = out_tdata[5:0];
        got.child_one = out_tdata[11:6];
        got.child_two = out_tdata[17:12];
        got.last      = out_tlast;
        if (children_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected beat pos %0d c1 %0d c2 %0d last %0b", $time,
                     got.position, got.child_one, got.child_two, got.last);
        end else begin
          want = children_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("%0t: beat differs, exp pos %0d c1 %0d c2 %0d last %0b,", $time,
                     want.position, want.child_one, want.child_two, want.last);
              $display(" got pos %0d c1 %0d c2 %0d last %0b",
                       got.position, got.child_one, got.child_two, got.last);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == MODE_LOAD) begin
          parent_one[in_tdata[5:0]] = in_tdata[11:6];
          parent_two[in_tdata[5:0]] = in_tdata[17:12];
        end else begin
          predict_children(in_tdata[23:18], in_tdata[29:24]);
        end
      end
    end
    beats_due <= children_due.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb import pmx_tb_pkg::*;;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;

  int mismatches;
  int beats_due;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int items_sent = 0;

  logic [5:0]  tour_one [64];
  logic [5:0]  tour_two [64];
  int          pool [64];
  logic [63:0] written = '0;

  pmx_permutation_crossover u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  pmx_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .beats_due  (beats_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (600) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  initial begin
    #(250_000_000);
    $display("pmx_permutation_crossover: mismatch");
    $finish;
  end

  function automatic int eff_len(input logic [6:0] v);
    if (v < 7'd2) return 2;
    if (v > 7'd64) return 64;
    return int'(v);
  endfunction

  function automatic logic [31:0] pack_in(input logic [5:0] pos, input logic [5:0] g1,
                                          input logic [5:0] g2, input logic [5:0] lo,
                                          input logic [5:0] hi);
    return {2'b00, hi, lo, g2, g1, pos};
  endfunction

  function automatic logic [5:0] rand_cut(input int n);
    if ($urandom_range(99) < 70) return 6'($urandom_range(n - 1));
    return 6'($urandom_range(63));
  endfunction

  function automatic bit all_loaded(input int n);
    int j;
    for (j = 0; j < n; j++)
      if (!written[j]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void shuffle_pool(input int len);
    int j, k, t;
    for (j = len - 1; j > 0; j--) begin
      k = $urandom_range(j);
      t = pool[j];
      pool[j] = pool[k];
      pool[k] = t;
    end
  endfunction

  task automatic send_beat(input pmx_mode_e mode, input logic [31:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_load(input logic [5:0] pos, input logic [5:0] g1, input logic [5:0] g2);
    send_beat(MODE_LOAD, pack_in(pos, g1, g2, 6'($urandom_range(63)),
                                 6'($urandom_range(63))));
    written[pos] = 1'b1;
  endtask

  task automatic send_cross(input logic [5:0] lo, input logic [5:0] hi);
    send_beat(MODE_CROSS, pack_in(6'($urandom_range(63)), 6'($urandom_range(63)),
                                  6'($urandom_range(63)), lo, hi));
  endtask

  task automatic write_len(input logic [6:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // permutations of 0..n-1, of a random gene subset, or plain noise
  task automatic load_tour(input int n);
    int kind, j;
    kind = $urandom_range(99);
    for (j = 0; j < 64; j++) pool[j] = j;
    if (kind >= 60) shuffle_pool(64);
    shuffle_pool(n);
    for (j = 0; j < n; j++) tour_one[j] = 6'(pool[j]);
    shuffle_pool(n);
    for (j = 0; j < n; j++) tour_two[j] = 6'(pool[j]);
    if (kind >= 85) begin
      for (j = 0; j < n; j++) begin
        tour_one[j] = 6'($urandom_range(63));
        tour_two[j] = 6'($urandom_range(63));
      end
    end
    for (j = 0; j < n; j++) pool[j] = j;
    shuffle_pool(n);
    for (j = 0; j < n; j++) begin
      if ($urandom_range(9) == 0)
        send_load(6'($urandom_range(63)), 6'($urandom_range(63)), 6'($urandom_range(63)));
      send_load(6'(pool[j]), tour_one[pool[j]], tour_two[pool[j]]);
    end
  endtask

  task automatic run_phase(input logic [6:0] len_cfg, input int idle_kind, input int quota,
                           input bit hold_off);
    int n, start;
    case (idle_kind)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
      default: begin sender_idle_pct = 34; receiver_stall_pct = 34; end
    endcase
    write_len(len_cfg);
    if (hold_off) hold_requests++;
    n = eff_len(len_cfg);
    start = items_sent;
    while (items_sent - start < quota) begin
      if (!all_loaded(n) || $urandom_range(99) < 70) load_tour(n);
      repeat ($urandom_range(1, 3)) send_cross(rand_cut(n), rand_cut(n));
    end
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // shortest tour, gene extremes, swapped and clamped cuts
    write_len(7'd0);
    send_load(6'd0, 6'd0, 6'd63);
    send_load(6'd1, 6'd63, 6'd0);
    send_cross(6'd0, 6'd0);
    send_cross(6'd63, 6'd0);
    send_cross(6'd1, 6'd63);
    settle();

    // non-permutation parents: a cycle in the map caps the chain walk
    write_len(7'd5);
    send_load(6'd0, 6'd0, 6'd1);
    send_load(6'd1, 6'd1, 6'd0);
    send_load(6'd2, 6'd0, 6'd2);
    send_load(6'd3, 6'd1, 6'd4);
    send_load(6'd4, 6'd3, 6'd3);
    send_load(6'd63, 6'd63, 6'd63);
    send_cross(6'd0, 6'd1);
    send_cross(6'd4, 6'd2);
    send_cross(6'd0, 6'd63);
    send_cross(6'd3, 6'd3);
    settle();

    run_phase(7'd64, 0, 20, 1'b0);
    run_phase(7'($urandom_range(3, 12)), 1, 45, 1'b0);
    run_phase(7'd1, 2, 30, 1'b0);
    run_phase(7'd127, 3, 20, 1'b0);
    run_phase(7'($urandom_range(3, 12)), 2, 45, 1'b1);
    run_phase(7'($urandom_range(13, 40)), 1, 45, 1'b0);
    run_phase(7'($urandom_range(3, 12)), 3, 45, 1'b0);
    run_phase(7'($urandom_range(2, 12)), 0, 45, 1'b0);

    if (mismatches == 0 && beats_due == 0)
      $display("pmx_permutation_crossover: match");
    else
      $display("pmx_permutation_crossover: mismatch");
    $finish;
  end

endmodule

>>> pmx_permutation_crossover.f
sv/pmx_pkg.sv
sv/pmx_ctrl.sv
sv/pmx_dpath.sv
sv/pmx_permutation_crossover.sv
bench/pmx_tb_pkg.sv
bench/pmx_checker.sv
bench/tb.sv
